>>> rtl/core/ssp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the structure similarity weighting
// Holds the request and result payload structs, the sideband that travels
// beside the divider, and the fixed widths of the datapath.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int SIM_BIAS  = 328;
    localparam int PIX_MAX   = 255;

    // Numerator (2*cross + 328) * 255 stays below 2^25.
    localparam int NUM_W     = 25;
    // Factor 2*cross + 328 and the divisor both stay below 2^18.
    localparam int FAC_W     = 18;
    localparam int DEN_W     = 18;
    // The quotient stays below 2^17, so the divider resolves 17 bits.
    localparam int DIV_STEPS = 17;
    localparam int SIM_W     = 16;
    localparam int PIX_W     = 8;
    localparam int PROD_W    = SIM_W + PIX_W;

    typedef struct packed {
        logic [15:0] cross_mean;
        logic [15:0] model_sq_mean;
        logic [15:0] live_sq_mean;
        logic [7:0]  diff_pixel;
        logic [7:0]  mask_pixel;
    } ssp_in_t;

    typedef struct packed {
        logic [15:0] similarity;
        logic [7:0]  pixel_out;
    } ssp_out_t;

    // Per-pixel data carried alongside the quotient.
    typedef struct packed {
        logic [PIX_W-1:0] diff;
        logic             match;
    } ssp_side_t;

endpackage
`default_nettype wire

>>> rtl/core/ssp_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_prep: numerator and divisor formation
// Two register stages: the biased sums first, then the multiplication of the
// numerator factor by 255 as a shift and subtract. The mask compare is done
// on entry and travels as one bit.
// ----------------------------------------------------------------------------
module ssp_prep
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       in_valid,
    input  wire ssp_pkg::ssp_in_t           in_data,
    input  wire logic [7:0]                 mask_match_value,
    output logic                            valid,
    output logic [ssp_pkg::NUM_W-1:0]       num,
    output logic [ssp_pkg::DEN_W-1:0]       den,
    output ssp_pkg::ssp_side_t              side
);

    logic                        a_valid_reg;
    logic [ssp_pkg::FAC_W-1:0]   a_fac_reg;
    logic [ssp_pkg::FAC_W-1:0]   a_fac_next;
    logic [ssp_pkg::DEN_W-1:0]   a_den_reg;
    logic [ssp_pkg::DEN_W-1:0]   a_den_next;
    ssp_pkg::ssp_side_t          a_side_reg;
    ssp_pkg::ssp_side_t          a_side_next;

    logic                        b_valid_reg;
    logic [ssp_pkg::NUM_W-1:0]   b_num_reg;
    logic [ssp_pkg::NUM_W:0]     b_num_full;
    logic [ssp_pkg::DEN_W-1:0]   b_den_reg;
    ssp_pkg::ssp_side_t          b_side_reg;

    always_comb
    begin
        a_fac_next = {1'b0, in_data.cross_mean, 1'b0}
                     + ssp_pkg::FAC_W'(ssp_pkg::SIM_BIAS);
        a_den_next = ssp_pkg::DEN_W'(in_data.model_sq_mean)
                     + ssp_pkg::DEN_W'(in_data.live_sq_mean)
                     + ssp_pkg::DEN_W'(ssp_pkg::SIM_BIAS);
        a_side_next.diff  = in_data.diff_pixel;
        a_side_next.match = (in_data.mask_pixel == mask_match_value);
    end

    // Multiply by 255 as (x << 8) - x.
    assign b_num_full = {a_fac_reg, 8'd0}
                        - (ssp_pkg::NUM_W + 1)'(a_fac_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_fac_reg  <= a_fac_next;
            a_den_reg  <= a_den_next;
            a_side_reg <= a_side_next;
            b_num_reg  <= b_num_full[ssp_pkg::NUM_W-1:0];
            b_den_reg  <= a_den_reg;
            b_side_reg <= a_side_reg;
        end
    end

    assign valid = b_valid_reg;
    assign num   = b_num_reg;
    assign den   = b_den_reg;
    assign side  = b_side_reg;

endmodule
`default_nettype wire

>>> rtl/core/ssp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_div: pipelined restoring divider
// One quotient bit per stage, one compare and subtract each. Only the low
// 16 bits of the quotient are kept, so the top bit falls off the shift.
// ----------------------------------------------------------------------------
module ssp_div
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       in_valid,
    input  wire logic [ssp_pkg::NUM_W-1:0]  num,
    input  wire logic [ssp_pkg::DEN_W-1:0]  den,
    input  wire ssp_pkg::ssp_side_t         in_side,
    output logic                            valid,
    output logic [ssp_pkg::SIM_W-1:0]       quo,
    output ssp_pkg::ssp_side_t              side
);

    localparam int STEPS = ssp_pkg::DIV_STEPS;

    logic                        valid_reg [STEPS];
    logic [ssp_pkg::NUM_W-1:0]   num_reg   [STEPS];
    logic [ssp_pkg::DEN_W-1:0]   den_reg   [STEPS];
    logic [ssp_pkg::DEN_W-1:0]   rem_reg   [STEPS];
    logic [ssp_pkg::SIM_W-1:0]   quo_reg   [STEPS];
    ssp_pkg::ssp_side_t          side_reg  [STEPS];

    logic                        valid_src [STEPS];
    logic [ssp_pkg::NUM_W-1:0]   num_src   [STEPS];
    logic [ssp_pkg::DEN_W-1:0]   den_src   [STEPS];
    logic [ssp_pkg::DEN_W-1:0]   rem_src   [STEPS];
    logic [ssp_pkg::SIM_W-1:0]   quo_src   [STEPS];
    ssp_pkg::ssp_side_t          side_src  [STEPS];

    // The top numerator bits are below the smallest divisor, so they seed
    // the partial remainder directly.
    always_comb
    begin
        valid_src[0] = in_valid;
        num_src[0]   = num;
        den_src[0]   = den;
        rem_src[0]   = ssp_pkg::DEN_W'(num[ssp_pkg::NUM_W-1:STEPS]);
        quo_src[0]   = '0;
        side_src[0]  = in_side;
        for (int k = 1; k < STEPS; k++)
        begin
            valid_src[k] = valid_reg[k-1];
            num_src[k]   = num_reg[k-1];
            den_src[k]   = den_reg[k-1];
            rem_src[k]   = rem_reg[k-1];
            quo_src[k]   = quo_reg[k-1];
            side_src[k]  = side_reg[k-1];
        end
    end

    genvar j;
    generate
        for (j = 0; j < STEPS; j++)
        begin : g_step
            localparam int BIT = STEPS - 1 - j;
            logic [ssp_pkg::DEN_W:0]   trial;
            logic [ssp_pkg::DEN_W:0]   diff;
            logic                      qbit;
            logic [ssp_pkg::DEN_W-1:0] rem_next;

            always_comb
            begin
                trial    = {rem_src[j], num_src[j][BIT]};
                diff     = trial - {1'b0, den_src[j]};
                qbit     = (trial >= {1'b0, den_src[j]});
                rem_next = qbit ? diff[ssp_pkg::DEN_W-1:0]
                                : trial[ssp_pkg::DEN_W-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j] <= 1'b0;
                end
                else if (adv)
                begin
                    valid_reg[j] <= valid_src[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    num_reg[j]  <= num_src[j];
                    den_reg[j]  <= den_src[j];
                    rem_reg[j]  <= rem_next;
                    quo_reg[j]  <= {quo_src[j][ssp_pkg::SIM_W-2:0], qbit};
                    side_reg[j] <= side_src[j];
                end
            end
        end
    endgenerate

    assign valid = valid_reg[STEPS-1];
    assign quo   = quo_reg[STEPS-1];
    assign side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

>>> rtl/core/ssp_weight.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_weight: difference pixel weighting and output register
// A multiply stage forms sim * (255 - diff); the output stage shifts,
// saturates at 255 and selects the weighted or the original pixel.
// ----------------------------------------------------------------------------
module ssp_weight
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       in_valid,
    input  wire logic [ssp_pkg::SIM_W-1:0]  sim,
    input  wire ssp_pkg::ssp_side_t         in_side,
    output logic                            valid,
    output ssp_pkg::ssp_out_t               data
);

    logic                         m_valid_reg;
    logic [ssp_pkg::PROD_W-1:0]   m_prod_reg;
    logic [ssp_pkg::SIM_W-1:0]    m_sim_reg;
    ssp_pkg::ssp_side_t           m_side_reg;
    logic [ssp_pkg::PIX_W-1:0]    m_inv;

    logic                         o_valid_reg;
    ssp_pkg::ssp_out_t            o_data_reg;
    ssp_pkg::ssp_out_t            o_data_next;
    logic [ssp_pkg::SIM_W-1:0]    shifted;
    logic [ssp_pkg::PIX_W-1:0]    sat;

    assign m_inv = ssp_pkg::PIX_W'(ssp_pkg::PIX_MAX) - in_side.diff;

    always_comb
    begin
        shifted = m_prod_reg[ssp_pkg::PROD_W-1:ssp_pkg::PIX_W];
        sat     = (|shifted[ssp_pkg::SIM_W-1:ssp_pkg::PIX_W])
                  ? ssp_pkg::PIX_W'(ssp_pkg::PIX_MAX)
                  : shifted[ssp_pkg::PIX_W-1:0];
        o_data_next.similarity = m_sim_reg;
        o_data_next.pixel_out  = m_side_reg.match
                                 ? ssp_pkg::PIX_W'(ssp_pkg::PIX_MAX) - sat
                                 : m_side_reg.diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= in_valid;
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_prod_reg <= ssp_pkg::PROD_W'(sim) * ssp_pkg::PROD_W'(m_inv);
            m_sim_reg  <= sim;
            m_side_reg <= in_side;
            o_data_reg <= o_data_next;
        end
    end

    assign valid = o_valid_reg;
    assign data  = o_data_reg;

endmodule
`default_nettype wire

>>> rtl/core/ssim_structure_pixel_weight_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssim_structure_pixel_weight_core: structure similarity pixel weighting
// Each request is one pixel with its blurred edge statistics, a difference
// pixel and a mask pixel. The result carries the similarity quotient and
// the difference pixel, weighted where the mask equals mask_match_value.
// Both channels use valid and stall; a request moves at a clock edge where
// valid is high and stall is low. The configuration register is written
// with cfg_wr_en and cfg_wr_data. The user must write it only while no pixel
// is in flight; the block does not enforce it. It has two preparation stages,
// 17 divider stages (one quotient bit each), a multiply stage and the output
// register. One pixel can enter every cycle unless in_stall is high. The
// whole pipeline advances together; when the output holds a result and
// out_stall is high, every stage holds and in_stall rises, so nothing is
// lost or repeated. Reset clears all valid bits and the mask register.
// ----------------------------------------------------------------------------
module ssim_structure_pixel_weight_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire ssp_pkg::ssp_in_t   in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ssp_pkg::ssp_out_t       out_data,
    input  wire logic               cfg_wr_en,
    input  wire logic [7:0]         cfg_wr_data
);

    logic [7:0]                  mask_match_value_reg;
    logic                        adv;

    logic                        prep_valid;
    logic [ssp_pkg::NUM_W-1:0]   prep_num;
    logic [ssp_pkg::DEN_W-1:0]   prep_den;
    ssp_pkg::ssp_side_t          prep_side;

    logic                        div_valid;
    logic [ssp_pkg::SIM_W-1:0]   div_quo;
    ssp_pkg::ssp_side_t          div_side;

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_match_value_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            mask_match_value_reg <= cfg_wr_data;
        end
    end

    ssp_prep u_prep
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (adv),
        .in_valid         (in_valid),
        .in_data          (in_data),
        .mask_match_value (mask_match_value_reg),
        .valid            (prep_valid),
        .num              (prep_num),
        .den              (prep_den),
        .side             (prep_side)
    );

    ssp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (prep_valid),
        .num      (prep_num),
        .den      (prep_den),
        .in_side  (prep_side),
        .valid    (div_valid),
        .quo      (div_quo),
        .side     (div_side)
    );

    ssp_weight u_weight
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (div_valid),
        .sim      (div_quo),
        .in_side  (div_side),
        .valid    (out_valid),
        .data     (out_data)
    );

endmodule
`default_nettype wire

>>> dv/tb_ssim_structure_pixel_weight_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ssim_structure_pixel_weight_core: self-checking bench for the weighting core
// Streams pixels through the core under several mask settings and compares
// every similarity and output pixel with a local integer model. Both channels
// idle in random bursts. The mask register changes only while the pipeline
// is empty.
// ----------------------------------------------------------------------------
module tb_ssim_structure_pixel_weight_core;

    localparam int PIPE_DEPTH  = 21;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_ITEMS = 260;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    ssp_pkg::ssp_in_t    in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    ssp_pkg::ssp_out_t   out_data;
    logic                cfg_wr_en = 1'b0;
    logic [7:0]          cfg_wr_data = 8'h00;

    ssp_pkg::ssp_in_t    pending_pixels[$];
    ssp_pkg::ssp_out_t   predicted_outputs[$];
    logic [7:0]  mask_value = 8'h00;
    logic        pixel_taken = 1'b0;
    logic        calm = 1'b0;
    int unsigned send_idle_level = 0;
    int unsigned recv_idle_level = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned pixels_checked = 0;
    int unsigned mask_hits = 0;
    int unsigned errors = 0;

    ssim_structure_pixel_weight_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Similarity quotient keeps only its low 16 bits, and the weighting uses
    // that wrapped value.
    function automatic ssp_pkg::ssp_out_t weigh_pixel(ssp_pkg::ssp_in_t px,
                                                      logic [7:0] match_val);
        int unsigned       numer;
        int unsigned       denom;
        int unsigned       quot;
        int unsigned       prod;
        int unsigned       shade;
        ssp_pkg::ssp_out_t r;
        numer = (32'(px.cross_mean) * 2 + ssp_pkg::SIM_BIAS) * ssp_pkg::PIX_MAX;
        denom = 32'(px.model_sq_mean) + 32'(px.live_sq_mean) + ssp_pkg::SIM_BIAS;
        quot = numer / denom;
        r.similarity = quot[15:0];
        r.pixel_out = px.diff_pixel;
        if (px.mask_pixel == match_val)
        begin
            prod = 32'(r.similarity) * (ssp_pkg::PIX_MAX - 32'(px.diff_pixel));
            shade = prod >> 8;
            if (shade > ssp_pkg::PIX_MAX)
                shade = ssp_pkg::PIX_MAX;
            r.pixel_out = 8'(ssp_pkg::PIX_MAX - shade);
        end
        return r;
    endfunction

    function automatic ssp_pkg::ssp_in_t make_pixel(logic [15:0] c, logic [15:0] m,
                                                    logic [15:0] l, logic [7:0] d,
                                                    logic [7:0] k);
        ssp_pkg::ssp_in_t p;
        p.cross_mean    = c;
        p.model_sq_mean = m;
        p.live_sq_mean  = l;
        p.diff_pixel    = d;
        p.mask_pixel    = k;
        return p;
    endfunction

    function automatic ssp_pkg::ssp_in_t random_pixel(logic [7:0] match_val);
        ssp_pkg::ssp_in_t p;
        int unsigned      a;
        int unsigned      b;
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
        case ($urandom_range(0, 3))
            0:
            begin
                p.cross_mean    = 16'($urandom);
                p.model_sq_mean = 16'($urandom);
                p.live_sq_mean  = 16'($urandom);
            end
            3:
            begin
                // Big cross term over small energies can push the quotient past 16 bits.
                p.cross_mean    = 16'($urandom_range(40000, 65535));
                p.model_sq_mean = 16'($urandom_range(0, 255));
                p.live_sq_mean  = 16'($urandom_range(0, 255));
            end
            default:
            begin
                // Statistics shaped like real edge pixels.
                p.cross_mean    = 16'(a * b + $urandom_range(0, 63));
                p.model_sq_mean = 16'(a * a);
                p.live_sq_mean  = 16'(b * b);
            end
        endcase
        if ($urandom_range(0, 3) == 0)
            p.diff_pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else
            p.diff_pixel = 8'($urandom);
        case ($urandom_range(0, 3))
            0:       p.mask_pixel = 8'($urandom);
            1:       p.mask_pixel = match_val ^ (8'h01 << $urandom_range(0, 7));
            default: p.mask_pixel = match_val;
        endcase
        return p;
    endfunction

    // Output check, prediction at input acceptance, idle level changes, watchdog.
    always @(posedge clk)
    begin : monitor
        ssp_pkg::ssp_out_t want;
        cycle_count <= cycle_count + 1;
        pixel_taken <= rst_n && in_valid && !in_stall;
        if (cycle_count % 200 == 0)
        begin
            send_idle_level <= $urandom_range(0, 3);
            recv_idle_level <= $urandom_range(0, 3);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_outputs.size() == 0)
            begin
                $display("%0t: unexpected result, similarity %0d pixel %0d",
                         $time, out_data.similarity, out_data.pixel_out);
                errors++;
            end
            else
            begin
                want = predicted_outputs.pop_front();
                pixels_checked++;
                if (out_data.similarity !== want.similarity)
                begin
                    $display("%0t: similarity mismatch, expected %0d, actual %0d",
                             $time, want.similarity, out_data.similarity);
                    errors++;
                end
                if (out_data.pixel_out !== want.pixel_out)
                begin
                    $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                             $time, want.pixel_out, out_data.pixel_out);
                    errors++;
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            predicted_outputs.push_back(weigh_pixel(in_data, mask_value));
            if (in_data.mask_pixel == mask_value)
                mask_hits++;
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin : driver
        logic             vld;
        ssp_pkg::ssp_in_t dat;
        vld = in_valid;
        dat = in_data;
        if (rst_n)
        begin
            if (in_valid && pixel_taken)
                vld = 1'b0;
            if (!vld)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_pixels.size() > 0)
                begin
                    dat = pending_pixels.pop_front();
                    vld = 1'b1;
                    if (!calm && $urandom_range(0, 7) < send_idle_level)
                        send_gap = $urandom_range(1, 15);
                end
            end
        end
        in_valid <= vld;
        in_data <= dat;
    end

    always @(negedge clk)
    begin : receiver
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!calm && $urandom_range(0, 15) < recv_idle_level)
                stall_left = $urandom_range(1, 15);
        end
    end

    task automatic write_mask_value(input logic [7:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        mask_value = v;
    endtask

    // The sender holds back here until every predicted result has arrived.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || in_valid || predicted_outputs.size() != 0);
        repeat (PIPE_DEPTH + 4) @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0] setting;
        @(posedge rst_n);
        @(negedge clk);

        // Directed pixels under the reset mask value of zero.
        pending_pixels.push_back(make_pixel(16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
        pending_pixels.push_back(make_pixel(16'hFFFF, 16'h0000, 16'h0000, 8'h00, 8'h00));
        pending_pixels.push_back(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h00));
        pending_pixels.push_back(make_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 8'h80, 8'h00));
        pending_pixels.push_back(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h5A, 8'hFF));
        pending_pixels.push_back(make_pixel(16'h8000, 16'h8000, 16'h8000, 8'h00, 8'h00));
        pending_pixels.push_back(make_pixel(16'h7FFF, 16'h7FFF, 16'hFFFF, 8'h7F, 8'h01));
        pending_pixels.push_back(make_pixel(16'd300, 16'h0000, 16'h0000, 8'h00, 8'h00));
        pending_pixels.push_back(make_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 8'hFF, 8'hFF));
        pending_pixels.push_back(make_pixel(16'h5555, 16'hAAAA, 16'h5555, 8'h55, 8'h00));
        pending_pixels.push_back(make_pixel(16'h0100, 16'h0100, 16'h0100, 8'hAA, 8'h80));
        pending_pixels.push_back(make_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 8'h01, 8'h00));
        // Quotient of exactly 65535, then the first one that wraps to zero.
        pending_pixels.push_back(make_pixel(16'hA400, 16'h0000, 16'h0000, 8'h00, 8'h00));
        pending_pixels.push_back(make_pixel(16'hA401, 16'h0000, 16'h0000, 8'h00, 8'h00));
        pending_pixels.push_back(make_pixel(16'hA401, 16'h0000, 16'h0000, 8'hFF, 8'h00));
        pending_pixels.push_back(make_pixel(16'h0000, 16'h0000, 16'h0000, 8'hFF, 8'h00));
        for (int i = 0; i < 320; i++)
            pending_pixels.push_back(random_pixel(mask_value));
        wait_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       setting = 8'hFF;
                1:       setting = 8'hA5;
                2:       setting = 8'h5A;
                3:       setting = 8'($urandom);
                default: setting = 8'h00;
            endcase
            // The final stretch runs with both sides at full rate.
            if (phase == 4)
                calm = 1'b1;
            write_mask_value(setting);
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_pixels.push_back(random_pixel(mask_value));
            wait_drained();
        end

        $display("Checked %0d pixels under 6 mask settings, %0d of them weighted.",
                 pixels_checked, mask_hits);
        $display("Errors found: %0d.", errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/core/ssp_pkg.sv
rtl/core/ssp_prep.sv
rtl/core/ssp_div.sv
rtl/core/ssp_weight.sv
rtl/core/ssim_structure_pixel_weight_core.sv
dv/tb_ssim_structure_pixel_weight_core.sv
